[rtl/usbep0_pkg.sv]
// Package with shared types, codes and the descriptor ROM image for the endpoint-0 engine.
package usbep0_pkg;

	localparam int EP0_SIZE_DEF  = 8;
	localparam int ROM_DEPTH_DEF = 256;
	localparam int IMAGE_LEN     = 242;

	typedef enum logic [1:0] {
		OP_SETUP   = 2'd0,
		OP_IN_DONE = 2'd1,
		OP_OUT_DONE = 2'd2,
		OP_BUS_RESET = 2'd3
	} op_t;

	localparam logic [1:0] IN_ACK   = 2'd0;
	localparam logic [1:0] IN_NAK   = 2'd1;
	localparam logic [1:0] IN_STALL = 2'd2;
	localparam logic       OUT_ACK   = 1'b0;
	localparam logic       OUT_STALL = 1'b1;

	localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
	localparam logic [7:0] REQ_GET_DESC      = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
	localparam logic [7:0] REQ_GET_IFACE     = 8'd10;
	localparam logic [7:0] REQ_STALLED       = 8'hFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       start;    // capture the event and run the decode
		logic       rom_step; // fetch the next packet byte from the ROM
		logic       emit;     // results are being shown on the output
		logic       advance;  // one result taken
	} cmd_t;

	typedef struct packed {
		logic       need_rom;   // packet bytes must be fetched from the ROM
		logic       fetch_done; // every ROM read of the packet has been issued
		logic       rom_done;   // all bytes of the packet fetched
		logic       last;       // the shown result is the final one
	} stat_t;

	function automatic logic [7:0] rom_image(input int a);
		logic [7:0] t [0:IMAGE_LEN-1];
		t = '{
		8'h12,8'h01,8'h10,8'h01,8'h00,8'h00,8'h00,8'h08,
		8'h88,8'h80,8'h07,8'h00,8'h01,8'h02,8'h01,8'h02,8'h00,8'h01,
		8'h09,8'h02,8'h52,8'h00,8'h02,8'h01,8'h00,8'hA0,8'h64,
		8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h01,8'h01,8'h00,
		8'h09,8'h21,8'h11,8'h01,8'h00,8'h01,8'h22,8'h3E,8'h00,
		8'h07,8'h05,8'h81,8'h03,8'h08,8'h00,8'h0A,
		8'h09,8'h04,8'h01,8'h00,8'h01,8'h03,8'h01,8'h02,8'h00,
		8'h09,8'h21,8'h10,8'h01,8'h00,8'h01,8'h22,8'h34,8'h00,
		8'h07,8'h05,8'h82,8'h03,8'h04,8'h00,8'h0A,
		8'h09,8'h04,8'h02,8'h00,8'h02,8'hFF,8'h80,8'h55,8'h00,
		8'h07,8'h05,8'h83,8'h02,8'h40,8'h00,8'h00,
		8'h07,8'h05,8'h04,8'h03,8'h40,8'h00,8'h00,
		8'h04,8'h03,8'h09,8'h04,
		8'h0A,8'h03,8'h4E,8'h00,8'h53,8'h00,8'h44,8'h00,8'h4E,8'h00,
		8'h0E,8'h03,8'h53,8'h00,8'h69,8'h00,8'h6D,8'h00,8'h50,8'h00,8'h61,8'h00,
		8'h64,8'h00,
		8'h05,8'h01,8'h09,8'h06,8'hA1,8'h01,8'h05,8'h07,8'h19,8'hE0,8'h29,8'hE7,
		8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h08,8'h81,8'h02,8'h95,8'h01,
		8'h75,8'h08,8'h81,8'h01,8'h95,8'h03,8'h75,8'h01,8'h05,8'h08,8'h19,8'h01,
		8'h29,8'h03,8'h91,8'h02,8'h95,8'h05,8'h75,8'h01,8'h91,8'h01,8'h95,8'h06,
		8'h75,8'h08,8'h26,8'hFF,8'h00,8'h05,8'h07,8'h19,8'h00,8'h29,8'h91,8'h81,
		8'h00,8'hC0,
		8'h05,8'h01,8'h09,8'h02,8'hA1,8'h01,8'h09,8'h01,8'hA1,8'h00,8'h05,8'h09,
		8'h19,8'h01,8'h29,8'h03,8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h03,
		8'h81,8'h02,8'h75,8'h05,8'h95,8'h01,8'h81,8'h01,8'h05,8'h01,8'h09,8'h30,
		8'h09,8'h31,8'h09,8'h38,8'h15,8'h81,8'h25,8'h7F,8'h75,8'h08,8'h95,8'h03,
		8'h81,8'h06,8'hC0,8'hC0};
		if (a < IMAGE_LEN) begin
			return t[a];
		end
		return 8'h00;
	endfunction

endpackage

[rtl/usbep0_if.sv]
// Valid/ready channel interface carrying one endpoint-0 event or one result byte.
interface usbep0_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [6:0]  rx_length;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] setup_value;
	logic [15:0] setup_index;
	logic [15:0] setup_length;
	modport source (output valid, operation, rx_length, request_type, request_code,
		setup_value, setup_index, setup_length, input ready);
	modport sink (input valid, operation, rx_length, request_type, request_code,
		setup_value, setup_index, setup_length, output ready);
endinterface

interface usbep0_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] in_response;
	logic       out_response;
	logic       in_toggle;
	logic [3:0] tx_length;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [6:0] device_address;
	logic [7:0] config_value;
	modport source (output valid, in_response, out_response, in_toggle, tx_length,
		data_byte, last_byte, device_address, config_value, input ready);
	modport sink (input valid, in_response, out_response, in_toggle, tx_length,
		data_byte, last_byte, device_address, config_value, output ready);
endinterface

[rtl/usbep0_ctrl.sv]
// Controller state machine sequencing decode, ROM fetch and result delivery.
module usbep0_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output usbep0_pkg::cmd_t   cmd,
	input  usbep0_pkg::stat_t  stat
);
	import usbep0_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_ROM;
			end
			ST_ROM: begin
				if (!stat.need_rom || stat.rom_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && stat.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		out_valid    = (state_q == ST_EMIT);
		cmd.start    = (state_q == ST_IDLE) && in_valid;
		cmd.rom_step = (state_q == ST_ROM) && stat.need_rom && !stat.fetch_done;
		cmd.emit     = (state_q == ST_EMIT);
		cmd.advance  = (state_q == ST_EMIT) && out_ready;
	end
endmodule

[rtl/usbep0_dp.sv]
// Datapath: request decode, endpoint state registers, descriptor ROM and packet buffer.
module usbep0_dp #(
	parameter int EP0_SIZE  = usbep0_pkg::EP0_SIZE_DEF,
	parameter int ROM_DEPTH = usbep0_pkg::ROM_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic [1:0]         operation,
	input  logic [6:0]         rx_length,
	input  logic [7:0]         request_type,
	input  logic [7:0]         request_code,
	input  logic [15:0]        setup_value,
	input  logic [15:0]        setup_index,
	input  logic [15:0]        setup_length,
	input  usbep0_pkg::cmd_t   cmd,
	output usbep0_pkg::stat_t  stat,
	output logic [1:0]         in_response,
	output logic               out_response,
	output logic               in_toggle,
	output logic [3:0]         tx_length,
	output logic [7:0]         data_byte,
	output logic               last_byte,
	output logic [6:0]         device_address,
	output logic [7:0]         config_value
);
	import usbep0_pkg::*;

	localparam int PKT_MAX = (EP0_SIZE < 8) ? EP0_SIZE : 8;
	localparam int AW = $clog2(ROM_DEPTH);

	logic [7:0] rom_rd_q;

	logic       wake_q;
	logic [7:0] pend_q;
	logic [6:0] rem_q;
	logic [7:0] ptr_q;
	logic [6:0] addr_q;
	logic [7:0] conf_q;
	logic       tog_q;
	logic [1:0] inr_q;
	logic       outr_q;
	logic [3:0] n_q;
	logic [7:0] buf_q [0:7];
	logic [3:0] fetch_q;    // bytes requested from the ROM
	logic [3:0] got_q;      // bytes written into the packet buffer
	logic       rd_pend_q;  // a ROM read is in flight
	logic [2:0] emit_q;
	logic       from_rom_q;

	// Setup decode.
	logic       ok;
	logic [6:0] rem_d;
	logic [7:0] ptr_d;
	logic [3:0] n_d;
	logic [6:0] wl_cap;
	logic [6:0] dlen;
	logic       is_desc;
	logic [7:0] il;
	logic [6:0] pkt_rem;

	always_comb begin
		ok = 1'b0;
		wl_cap = (setup_length > 16'd127) ? 7'h7F : setup_length[6:0];
		rem_d = wl_cap;
		ptr_d = ptr_q;
		n_d = 4'd0;
		dlen = 7'd0;
		is_desc = 1'b0;
		il = setup_index[7:0];
		if (rx_length == 7'd8 && request_type[6:5] == 2'b00) begin
			case (request_code)
				REQ_GET_DESC: begin
					case (setup_value[15:8])
						8'h01: begin ok = 1'b1; ptr_d = 8'd0; dlen = 7'd18; end
						8'h02: begin ok = 1'b1; ptr_d = 8'd18; dlen = 7'd82; end
						8'h03: begin
							case (setup_value[7:0])
								8'h00: begin ok = 1'b1; ptr_d = 8'd100; dlen = 7'd4; end
								8'h01: begin ok = 1'b1; ptr_d = 8'd104; dlen = 7'd10; end
								8'h02: begin ok = 1'b1; ptr_d = 8'd114; dlen = 7'd14; end
								default: ok = 1'b0;
							endcase
						end
						8'h22: begin
							if (il == 8'd0) begin ok = 1'b1; ptr_d = 8'd128; dlen = 7'd62; end
							else if (il == 8'd1) begin
								ok = 1'b1; ptr_d = 8'd190; dlen = 7'd52;
							end
						end
						default: ok = 1'b0;
					endcase
					is_desc = ok;
					if (ok && wl_cap > dlen) rem_d = dlen;
					if (ok) n_d = (rem_d < 7'(PKT_MAX)) ? rem_d[3:0] : 4'(PKT_MAX);
				end
				REQ_SET_ADDRESS: begin ok = 1'b1; rem_d = setup_value[6:0]; end
				REQ_GET_CONFIG, REQ_GET_IFACE: begin
					ok = 1'b1; n_d = (wl_cap != 7'd0) ? 4'd1 : 4'd0;
				end
				REQ_SET_CONFIG: ok = 1'b1;
				REQ_CLEAR_FEATURE: begin
					if (request_type[4:0] == 5'd0) ok = 1'b1;
					else if (request_type[4:0] == 5'd2)
						ok = (il == 8'h81) || (il == 8'h82) || (il == 8'h83) ||
							(il == 8'h01) || (il == 8'h04);
				end
				REQ_SET_FEATURE: begin
					if (request_type[4:0] == 5'd0)
						ok = (setup_value == 16'd1) && wake_q;
					else if (request_type[4:0] == 5'd2)
						ok = (setup_value == 16'd0) && ((setup_index == 16'h82) ||
							(setup_index == 16'h02) || (setup_index == 16'h81));
				end
				REQ_GET_STATUS: begin
					ok = 1'b1; n_d = (wl_cap >= 7'd2) ? 4'd2 : wl_cap[3:0];
				end
				default: ok = 1'b0;
			endcase
		end
		pkt_rem = (rem_q < 7'(PKT_MAX)) ? rem_q : 7'(PKT_MAX);
	end

	// The descriptor ROM is a constant table behind one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.rom_step) rom_rd_q <= rom_image(int'(AW'(ptr_q + 8'(fetch_q))));
	end

	logic [2:0] wr_idx;
	assign wr_idx = got_q[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_q <= 1'b1; pend_q <= 8'd0; rem_q <= 7'd0; ptr_q <= 8'd0;
			addr_q <= 7'd0; conf_q <= 8'd0; tog_q <= 1'b1;
			inr_q <= IN_NAK; outr_q <= OUT_ACK; n_q <= 4'd0;
			fetch_q <= 4'd0; got_q <= 4'd0; rd_pend_q <= 1'b0; emit_q <= 3'd0;
			from_rom_q <= 1'b0;
		end else begin
			if (cfg_we) wake_q <= cfg_wdata;
			rd_pend_q <= cmd.rom_step;
			if (cmd.start) begin
				fetch_q <= 4'd0; got_q <= 4'd0; emit_q <= 3'd0;
				case (op_t'(operation))
					OP_SETUP: begin
						tog_q <= 1'b1;
						if (ok) begin
							inr_q <= IN_ACK; outr_q <= OUT_ACK;
							pend_q <= request_code;
							n_q <= n_d;
							from_rom_q <= is_desc;
							if (is_desc) begin
								rem_q <= rem_d - 7'(n_d);
								ptr_q <= ptr_d;
							end else begin
								rem_q <= rem_d;
							end
							if (request_code == REQ_SET_CONFIG) conf_q <= setup_value[7:0];
						end else begin
							inr_q <= IN_STALL; outr_q <= OUT_STALL; pend_q <= REQ_STALLED;
							n_q <= 4'd0; from_rom_q <= 1'b0;
							if (rx_length == 7'd8) rem_q <= wl_cap;
						end
					end
					OP_IN_DONE: begin
						outr_q <= OUT_ACK;
						if (pend_q == REQ_GET_DESC) begin
							inr_q <= IN_ACK; tog_q <= ~tog_q;
							n_q <= pkt_rem[3:0]; from_rom_q <= 1'b1;
							rem_q <= rem_q - pkt_rem;
						end else begin
							inr_q <= IN_NAK; n_q <= 4'd0; from_rom_q <= 1'b0;
							if (pend_q == REQ_SET_ADDRESS) addr_q <= rem_q;
							tog_q <= 1'b0;
						end
					end
					OP_OUT_DONE: begin
						inr_q <= IN_NAK; outr_q <= OUT_ACK; n_q <= 4'd0;
						from_rom_q <= 1'b0; tog_q <= 1'b0;
					end
					default: begin
						inr_q <= IN_NAK; outr_q <= OUT_ACK; n_q <= 4'd0;
						from_rom_q <= 1'b0; addr_q <= 7'd0; tog_q <= 1'b0;
					end
				endcase
			end else begin
				if (rd_pend_q) got_q <= got_q + 4'd1;
				if (cmd.rom_step) fetch_q <= fetch_q + 4'd1;
				if (cmd.advance) emit_q <= emit_q + 3'd1;
				// The descriptor pointer moves past the packet when its first result is taken.
				if (stat.rom_done && from_rom_q && cmd.emit && emit_q == 3'd0 && cmd.advance)
					ptr_q <= ptr_q + 8'(n_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			buf_q[0] <= (op_t'(operation) == OP_SETUP && request_code == REQ_GET_CONFIG) ?
				conf_q : 8'd0;
			for (int i = 1; i < 8; i++) buf_q[i] <= 8'd0;
		end else if (rd_pend_q) begin
			buf_q[wr_idx] <= rom_rd_q;
		end
	end

	assign stat.need_rom   = from_rom_q && (n_q != 4'd0);
	assign stat.fetch_done = (fetch_q == n_q);
	assign stat.rom_done   = stat.fetch_done && (got_q == n_q) && !rd_pend_q;
	assign stat.last       = (n_q == 4'd0) || (4'(emit_q) + 4'd1 == n_q);

	assign in_response    = inr_q;
	assign out_response   = outr_q;
	assign in_toggle      = tog_q;
	assign tx_length      = n_q;
	assign data_byte      = (n_q != 4'd0) ? buf_q[emit_q] : 8'd0;
	assign last_byte      = stat.last;
	assign device_address = addr_q;
	assign config_value   = conf_q;
endmodule

[rtl/usb_control_endpoint_engine.sv]
// Top level of the endpoint-0 standard request engine.
// Usage: one request on the evt channel is one endpoint-0 event (setup, IN done,
// OUT done, bus reset). The engine answers with one to eight result requests on
// the res channel, one per byte of the next IN packet, the last one marked by
// last_byte. A packet with no data still yields a single result with tx_length 0.
// The decode is combinational and is registered when the event is taken;
// descriptor bytes are then read from the descriptor ROM at one byte a cycle
// through its single registered read port before the first result is shown.
// Results then leave at one a cycle while res.ready is high, and the next event
// is taken in the cycle after the last result. One event is handled at a time.
// A stalled receiver simply holds the current result; no input is taken
// until every result of the event has gone.
// Reset (arst_n low): address, configuration, pending request and length clear,
// the IN toggle is set and remote wakeup is enabled; the descriptor ROM holds a
// constant image. The remote_wakeup_capable register is written through
// cfg_we / cfg_wdata.
module usb_control_endpoint_engine #(
	parameter int EP0_SIZE  = usbep0_pkg::EP0_SIZE_DEF,
	parameter int ROM_DEPTH = usbep0_pkg::ROM_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	usbep0_evt_if.sink    evt,
	usbep0_res_if.source  res
);
	import usbep0_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The controller decides when to accept an event and when results are shown.
	usbep0_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.in_ready (evt.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// The datapath holds all endpoint state and the descriptor ROM.
	usbep0_dp #(.EP0_SIZE(EP0_SIZE), .ROM_DEPTH(ROM_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (evt.operation),
		.rx_length     (evt.rx_length),
		.request_type  (evt.request_type),
		.request_code  (evt.request_code),
		.setup_value   (evt.setup_value),
		.setup_index   (evt.setup_index),
		.setup_length  (evt.setup_length),
		.cmd           (cmd),
		.stat          (stat),
		.in_response   (res.in_response),
		.out_response  (res.out_response),
		.in_toggle     (res.in_toggle),
		.tx_length     (res.tx_length),
		.data_byte     (res.data_byte),
		.last_byte     (res.last_byte),
		.device_address(res.device_address),
		.config_value  (res.config_value)
	);
endmodule

[tb/usb_control_endpoint_engine_tb.sv]
// Self-checking testbench for the endpoint-0 standard request engine.
module usb_control_endpoint_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import usbep0_pkg::*;

	// One endpoint-0 event as the host side presents it.
	typedef struct {
		op_t         op;
		logic [6:0]  rxl;
		logic [7:0]  rtype;
		logic [7:0]  rcode;
		logic [15:0] wval;
		logic [15:0] widx;
		logic [15:0] wlen;
	} ev_t;

	// One result request: handshakes, toggle and one byte of the IN packet.
	typedef struct packed {
		logic [1:0] in_resp;
		logic       out_resp;
		logic       tog;
		logic [3:0] len;
		logic [7:0] data;
		logic       last;
		logic [6:0] addr;
		logic [7:0] cfg;
	} res_t;

	// A directed row; where has_exp is set, the handshakes and the packet
	// length are typed in by hand rather than taken from the predictor.
	typedef struct {
		ev_t        ev;
		bit         has_exp;
		logic [1:0] e_in;
		logic       e_out;
		logic [3:0] e_len;
	} row_t;

	// Descriptor image: device, configuration, strings and two report descriptors.
	localparam logic [7:0] IMG [0:241] = '{
		8'h12,8'h01,8'h10,8'h01,8'h00,8'h00,8'h00,8'h08,
		8'h88,8'h80,8'h07,8'h00,8'h01,8'h02,8'h01,8'h02,8'h00,8'h01,
		8'h09,8'h02,8'h52,8'h00,8'h02,8'h01,8'h00,8'hA0,8'h64,
		8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h01,8'h01,8'h00,
		8'h09,8'h21,8'h11,8'h01,8'h00,8'h01,8'h22,8'h3E,8'h00,
		8'h07,8'h05,8'h81,8'h03,8'h08,8'h00,8'h0A,
		8'h09,8'h04,8'h01,8'h00,8'h01,8'h03,8'h01,8'h02,8'h00,
		8'h09,8'h21,8'h10,8'h01,8'h00,8'h01,8'h22,8'h34,8'h00,
		8'h07,8'h05,8'h82,8'h03,8'h04,8'h00,8'h0A,
		8'h09,8'h04,8'h02,8'h00,8'h02,8'hFF,8'h80,8'h55,8'h00,
		8'h07,8'h05,8'h83,8'h02,8'h40,8'h00,8'h00,
		8'h07,8'h05,8'h04,8'h03,8'h40,8'h00,8'h00,
		8'h04,8'h03,8'h09,8'h04,
		8'h0A,8'h03,8'h4E,8'h00,8'h53,8'h00,8'h44,8'h00,8'h4E,8'h00,
		8'h0E,8'h03,8'h53,8'h00,8'h69,8'h00,8'h6D,8'h00,8'h50,8'h00,8'h61,8'h00,
		8'h64,8'h00,
		8'h05,8'h01,8'h09,8'h06,8'hA1,8'h01,8'h05,8'h07,8'h19,8'hE0,8'h29,8'hE7,
		8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h08,8'h81,8'h02,8'h95,8'h01,
		8'h75,8'h08,8'h81,8'h01,8'h95,8'h03,8'h75,8'h01,8'h05,8'h08,8'h19,8'h01,
		8'h29,8'h03,8'h91,8'h02,8'h95,8'h05,8'h75,8'h01,8'h91,8'h01,8'h95,8'h06,
		8'h75,8'h08,8'h26,8'hFF,8'h00,8'h05,8'h07,8'h19,8'h00,8'h29,8'h91,8'h81,
		8'h00,8'hC0,
		8'h05,8'h01,8'h09,8'h02,8'hA1,8'h01,8'h09,8'h01,8'hA1,8'h00,8'h05,8'h09,
		8'h19,8'h01,8'h29,8'h03,8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h03,
		8'h81,8'h02,8'h75,8'h05,8'h95,8'h01,8'h81,8'h01,8'h05,8'h01,8'h09,8'h30,
		8'h09,8'h31,8'h09,8'h38,8'h15,8'h81,8'h25,8'h7F,8'h75,8'h08,8'h95,8'h03,
		8'h81,8'h06,8'hC0,8'hC0};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	usbep0_evt_if evt_ch();
	usbep0_res_if res_ch();

	usb_control_endpoint_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.evt(evt_ch),
		.res(res_ch)
	);

	// Shadow state of the engine, kept in step with every accepted request.
	logic       wake_en;
	logic [7:0] pend_req;
	logic [6:0] rem_len;
	logic [7:0] rom_ptr;
	logic [6:0] addr_q;
	logic [7:0] conf_q;
	logic       tog_q;
	logic [7:0] desc_rom [0:255];
	logic [7:0] pkt_buf [0:7];
	int         pkt_n;

	res_t expected_results [$];
	row_t directed_rows [$];
	int   mismatches;
	int   events_sent;
	int   results_seen;
	bit   no_gaps;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The run is ended here if the engine stops answering.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic ev_t mk_ev(op_t op, int rxl, int rt, int rc, int v, int ix, int wl);
		ev_t e;
		e.op = op;
		e.rxl = rxl[6:0];
		e.rtype = rt[7:0];
		e.rcode = rc[7:0];
		e.wval = v[15:0];
		e.widx = ix[15:0];
		e.wlen = wl[15:0];
		return e;
	endfunction

	// Copies the next packet out of the descriptor ROM, at most eight bytes.
	function automatic void fetch_packet();
		int i;
		pkt_n = (rem_len < 8) ? rem_len : 8;
		for (i = 0; i < pkt_n; i++) begin
			pkt_buf[i] = desc_rom[8'(rom_ptr + i)];
		end
		rem_len = 7'(rem_len - pkt_n);
		rom_ptr = 8'(rom_ptr + pkt_n);
	endfunction

	// Decodes one setup; returns 0 where the request must be stalled.
	function automatic bit decode_setup(ev_t e);
		logic [4:0] recip;
		int dlen;
		int dptr;
		recip = e.rtype[4:0];
		pkt_n = 0;
		rem_len = (e.wlen > 16'h7F) ? 7'h7F : e.wlen[6:0];
		pend_req = e.rcode;
		if (e.rtype[6:5] != 2'b00) begin
			return 1'b0;
		end
		case (e.rcode)
			REQ_GET_DESC: begin
				case (e.wval[15:8])
					8'h01: begin dptr = 0; dlen = 18; end
					8'h02: begin dptr = 18; dlen = 82; end
					8'h03: begin
						case (e.wval[7:0])
							8'h00: begin dptr = 100; dlen = 4; end
							8'h01: begin dptr = 104; dlen = 10; end
							8'h02: begin dptr = 114; dlen = 14; end
							default: return 1'b0;
						endcase
					end
					8'h22: begin
						if (e.widx[7:0] == 8'h00) begin
							dptr = 128; dlen = 62;
						end else if (e.widx[7:0] == 8'h01) begin
							dptr = 190; dlen = 52;
						end else begin
							return 1'b0;
						end
					end
					default: return 1'b0;
				endcase
				if (rem_len > dlen) begin
					rem_len = dlen[6:0];
				end
				rom_ptr = dptr[7:0];
				fetch_packet();
				return 1'b1;
			end
			REQ_SET_ADDRESS: begin
				rem_len = e.wval[6:0];
				return 1'b1;
			end
			REQ_GET_CONFIG: begin
				pkt_buf[0] = conf_q;
				pkt_n = (rem_len >= 1) ? 1 : 0;
				return 1'b1;
			end
			REQ_SET_CONFIG: begin
				conf_q = e.wval[7:0];
				return 1'b1;
			end
			REQ_CLEAR_FEATURE: begin
				if (recip == 5'd0) begin
					return 1'b1;
				end
				if (recip == 5'd2) begin
					return e.widx[7:0] inside {8'h81, 8'h82, 8'h83, 8'h01, 8'h04};
				end
				return 1'b0;
			end
			REQ_SET_FEATURE: begin
				if (recip == 5'd0) begin
					return (e.wval == 16'd1) && wake_en;
				end
				if (recip == 5'd2) begin
					return (e.wval == 16'd0) && (e.widx inside {16'h82, 16'h02, 16'h81});
				end
				return 1'b0;
			end
			REQ_GET_IFACE: begin
				pkt_buf[0] = 8'h00;
				pkt_n = (rem_len >= 1) ? 1 : 0;
				return 1'b1;
			end
			REQ_GET_STATUS: begin
				pkt_buf[0] = 8'h00;
				pkt_buf[1] = 8'h00;
				pkt_n = (rem_len >= 2) ? 2 : rem_len;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Advances the shadow state by one event and queues the results it causes.
	function automatic int predict_event(ev_t e);
		logic [1:0] inr;
		logic outr;
		bit ok;
		int cnt;
		int k;
		res_t r;
		inr = IN_NAK;
		outr = OUT_ACK;
		pkt_n = 0;
		for (k = 0; k < 8; k++) begin
			pkt_buf[k] = 8'h00;
		end
		case (e.op)
			OP_SETUP: begin
				ok = 1'b0;
				if (e.rxl == 7'd8) begin
					ok = decode_setup(e);
				end
				tog_q = 1'b1;
				if (ok) begin
					inr = IN_ACK;
				end else begin
					pend_req = REQ_STALLED;
					pkt_n = 0;
					inr = IN_STALL;
					outr = OUT_STALL;
				end
			end
			OP_IN_DONE: begin
				if (pend_req == REQ_GET_DESC) begin
					fetch_packet();
					tog_q = ~tog_q;
					inr = IN_ACK;
				end else begin
					// A pending set address takes effect on the status stage.
					if (pend_req == REQ_SET_ADDRESS) begin
						addr_q = rem_len;
					end
					tog_q = 1'b0;
				end
			end
			OP_OUT_DONE: begin
				tog_q = 1'b0;
			end
			default: begin
				addr_q = 7'd0;
				tog_q = 1'b0;
			end
		endcase
		cnt = (pkt_n != 0) ? pkt_n : 1;
		for (k = 0; k < cnt; k++) begin
			r.in_resp = inr;
			r.out_resp = outr;
			r.tog = tog_q;
			r.len = pkt_n[3:0];
			r.data = (pkt_n != 0) ? pkt_buf[k] : 8'h00;
			r.last = (k + 1 == cnt);
			r.addr = addr_q;
			r.cfg = conf_q;
			expected_results.push_back(r);
		end
		return cnt;
	endfunction

	// Random event: mostly well-formed standard requests followed by IN done
	// events that drain descriptors, with some malformed setups and noise.
	function automatic ev_t random_event();
		ev_t e;
		int r;
		e = mk_ev(OP_SETUP, 8, 8'h80, 0, $urandom, $urandom, $urandom);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			e.op = OP_SETUP;
		end else if (r < 85) begin
			e.op = OP_IN_DONE;
		end else if (r < 92) begin
			e.op = OP_OUT_DONE;
		end else begin
			e.op = OP_BUS_RESET;
		end
		e.rxl = ($urandom_range(0, 99) < 85) ? 7'd8 : 7'($urandom_range(0, 64));
		case ($urandom_range(0, 9))
			0: e.rtype = 8'($urandom);
			1: e.rtype = 8'h00;
			2: e.rtype = 8'h02;
			3: e.rtype = 8'h01;
			4: e.rtype = 8'h82;
			default: e.rtype = 8'h80;
		endcase
		case ($urandom_range(0, 11))
			0: e.rcode = 8'($urandom);
			1: e.rcode = REQ_GET_STATUS;
			2: e.rcode = REQ_CLEAR_FEATURE;
			3: e.rcode = REQ_SET_FEATURE;
			4: e.rcode = REQ_SET_ADDRESS;
			5: e.rcode = REQ_GET_CONFIG;
			6: e.rcode = REQ_SET_CONFIG;
			7: e.rcode = REQ_GET_IFACE;
			default: e.rcode = REQ_GET_DESC;
		endcase
		if ($urandom_range(0, 3) != 0) begin
			if (e.rcode == REQ_GET_DESC) begin
				case ($urandom_range(0, 4))
					0: e.wval[15:8] = 8'h01;
					1: e.wval[15:8] = 8'h02;
					2: e.wval[15:8] = 8'h03;
					3: e.wval[15:8] = 8'h22;
					default: e.wval[15:8] = 8'($urandom_range(0, 4));
				endcase
				e.wval[7:0] = 8'($urandom_range(0, 3));
			end else if (e.rcode inside {REQ_SET_FEATURE, REQ_CLEAR_FEATURE}) begin
				e.wval = 16'($urandom_range(0, 2));
			end
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 6))
				0: e.widx = 16'h0081;
				1: e.widx = 16'h0082;
				2: e.widx = 16'h0083;
				3: e.widx = 16'h0001;
				4: e.widx = 16'h0004;
				5: e.widx = 16'h0002;
				default: e.widx = 16'($urandom_range(0, 3));
			endcase
		end
		case ($urandom_range(0, 3))
			0: e.wlen = 16'($urandom_range(0, 9));
			1: e.wlen = 16'($urandom_range(0, 127));
			2: e.wlen = 16'hFFFF;
			default: e.wlen = 16'($urandom);
		endcase
		return e;
	endfunction

	// Offers one request and waits for the engine to take it.
	task automatic send_event(ev_t e, bit has_exp, logic [1:0] e_in, logic e_out,
			logic [3:0] e_len);
		int gap;
		int cnt;
		int k;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			evt_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		evt_ch.valid <= 1'b1;
		evt_ch.operation <= e.op;
		evt_ch.rx_length <= e.rxl;
		evt_ch.request_type <= e.rtype;
		evt_ch.request_code <= e.rcode;
		evt_ch.setup_value <= e.wval;
		evt_ch.setup_index <= e.widx;
		evt_ch.setup_length <= e.wlen;
		@(posedge clk);
		while (!evt_ch.ready) begin
			@(posedge clk);
		end
		cnt = predict_event(e);
		events_sent++;
		// Hand-typed values take the place of the predicted ones for this row.
		if (has_exp) begin
			for (k = expected_results.size() - cnt; k < expected_results.size(); k++) begin
				expected_results[k].in_resp = e_in;
				expected_results[k].out_resp = e_out;
				expected_results[k].len = e_len;
			end
		end
	endtask

	// Lets the engine drain completely, then writes the wakeup register.
	task automatic write_wakeup(logic v);
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (30) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		wake_en = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_row(ev_t e, bit has_exp, logic [1:0] e_in, logic e_out,
			logic [3:0] e_len);
		row_t r;
		r.ev = e;
		r.has_exp = has_exp;
		r.e_in = e_in;
		r.e_out = e_out;
		r.e_len = e_len;
		directed_rows.push_back(r);
	endtask

	// Result side: random back-pressure at the falling edge, checking at the rising edge.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			int gap;
			@(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.in_resp = res_ch.in_response;
			got.out_resp = res_ch.out_response;
			got.tog = res_ch.in_toggle;
			got.len = res_ch.tx_length;
			got.data = res_ch.data_byte;
			got.last = res_ch.last_byte;
			got.addr = res_ch.device_address;
			got.cfg = res_ch.config_value;
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: in %0d out %0d tog %0d len %0d data %h",
						got.in_resp, got.out_resp, got.tog, got.len, got.data);
				end
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at result %0d:", results_seen);
						$display("  expected in %0d out %0d tog %0d len %0d data %h",
							want.in_resp, want.out_resp, want.tog, want.len, want.data);
						$display("           last %0d addr %0d cfg %0d",
							want.last, want.addr, want.cfg);
						$display("  actual   in %0d out %0d tog %0d len %0d data %h",
							got.in_resp, got.out_resp, got.tog, got.len, got.data);
						$display("           last %0d addr %0d cfg %0d",
							got.last, got.addr, got.cfg);
					end
				end
			end
		end
	end

	initial begin
		int i;
		int phase;
		row_t r;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.operation = OP_SETUP;
		evt_ch.rx_length = '0;
		evt_ch.request_type = '0;
		evt_ch.request_code = '0;
		evt_ch.setup_value = '0;
		evt_ch.setup_index = '0;
		evt_ch.setup_length = '0;
		mismatches = 0;
		events_sent = 0;
		results_seen = 0;
		no_gaps = 1'b0;

		// Shadow state after reset.
		wake_en = 1'b1;
		pend_req = 8'h00;
		rem_len = 7'd0;
		rom_ptr = 8'h00;
		addr_q = 7'd0;
		conf_q = 8'h00;
		tog_q = 1'b1;
		for (i = 0; i < 256; i++) begin
			desc_rom[i] = (i < 242) ? IMG[i] : 8'h00;
		end

		// Directed part: reset state, every standard request, the stall cases.
		add_row(mk_ev(OP_IN_DONE, 0, 0, 0, 0, 0, 0), 1, IN_NAK, OUT_ACK, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h80, REQ_GET_DESC, 16'h0100, 0, 16'hFFFF),
			1, IN_ACK, OUT_ACK, 4'd8);
		add_row(mk_ev(OP_IN_DONE, 0, 0, 0, 0, 0, 0), 1, IN_ACK, OUT_ACK, 4'd8);
		add_row(mk_ev(OP_IN_DONE, 0, 0, 0, 0, 0, 0), 1, IN_ACK, OUT_ACK, 4'd2);
		add_row(mk_ev(OP_IN_DONE, 0, 0, 0, 0, 0, 0), 1, IN_ACK, OUT_ACK, 4'd0);
		// A setup that is not eight bytes long is stalled.
		add_row(mk_ev(OP_SETUP, 7, 8'h80, REQ_GET_DESC, 16'h0100, 0, 64),
			1, IN_STALL, OUT_STALL, 4'd0);
		// A class request is stalled, like any request that is not of the standard type.
		add_row(mk_ev(OP_SETUP, 8, 8'hA0, REQ_GET_DESC, 16'h0100, 0, 64),
			1, IN_STALL, OUT_STALL, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h80, REQ_GET_DESC, 16'h0200, 0, 9), 0, 0, 0, 0);
		add_row(mk_ev(OP_OUT_DONE, 0, 0, 0, 0, 0, 0), 1, IN_NAK, OUT_ACK, 4'd0);
		add_row(mk_ev(OP_IN_DONE, 64, 0, 0, 0, 0, 0), 0, 0, 0, 0);
		add_row(mk_ev(OP_SETUP, 8, 8'h80, REQ_GET_DESC, 16'h0302, 0, 255), 0, 0, 0, 0);
		add_row(mk_ev(OP_SETUP, 8, 8'h80, REQ_GET_DESC, 16'h0303, 0, 255),
			1, IN_STALL, OUT_STALL, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h81, REQ_GET_DESC, 16'h2200, 16'h0001, 255), 0, 0, 0, 0);
		add_row(mk_ev(OP_SETUP, 8, 8'h81, REQ_GET_DESC, 16'h2200, 16'hFF02, 255),
			1, IN_STALL, OUT_STALL, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h80, REQ_GET_DESC, 16'h0000, 0, 255),
			1, IN_STALL, OUT_STALL, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h00, REQ_SET_ADDRESS, 16'hFFFF, 0, 0), 0, 0, 0, 0);
		add_row(mk_ev(OP_IN_DONE, 0, 0, 0, 0, 0, 0), 1, IN_NAK, OUT_ACK, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h00, REQ_SET_CONFIG, 16'h00FF, 0, 0), 0, 0, 0, 0);
		add_row(mk_ev(OP_SETUP, 8, 8'h80, REQ_GET_CONFIG, 0, 0, 1), 1, IN_ACK, OUT_ACK, 4'd1);
		add_row(mk_ev(OP_BUS_RESET, 0, 0, 0, 0, 0, 0), 1, IN_NAK, OUT_ACK, 4'd0);
		// Endpoint clear feature on a known endpoint now succeeds.
		add_row(mk_ev(OP_SETUP, 8, 8'h02, REQ_CLEAR_FEATURE, 0, 16'h0081, 0),
			1, IN_ACK, OUT_ACK, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h02, REQ_CLEAR_FEATURE, 0, 16'h0005, 0),
			1, IN_STALL, OUT_STALL, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h00, REQ_SET_FEATURE, 1, 0, 0), 1, IN_ACK, OUT_ACK, 4'd0);
		add_row(mk_ev(OP_SETUP, 8, 8'h81, REQ_GET_IFACE, 0, 0, 16'hFFFF), 0, 0, 0, 0);
		add_row(mk_ev(OP_SETUP, 8, 8'h82, REQ_GET_STATUS, 0, 0, 16'hFFFF),
			1, IN_ACK, OUT_ACK, 4'd2);
		add_row(mk_ev(OP_SETUP, 8, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			1, IN_STALL, OUT_STALL, 4'd0);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			send_event(r.ev, r.has_exp, r.e_in, r.e_out, r.e_len);
		end

		// Random part in phases; the sender waits for a full drain before each
		// register write, and one phase runs with no idling at all.
		for (phase = 0; phase < 5; phase++) begin
			write_wakeup(phase[0]);
			no_gaps = (phase == 2);
			for (i = 0; i < 95; i++) begin
				send_event(random_event(), 0, 0, 0, 0);
			end
		end

		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);

		$display("Covered %0d endpoint-0 events and %0d result requests,", events_sent,
			results_seen);
		$display("with both wakeup settings and random stalls on both channels.");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/usbep0_pkg.sv
rtl/usbep0_if.sv
rtl/usbep0_ctrl.sv
rtl/usbep0_dp.sv
rtl/usb_control_endpoint_engine.sv
tb/usb_control_endpoint_engine_tb.sv
